>>> rtl/lsfh_pkg.sv
// Package for the LIN slave frame handler: result kinds, queue command,
// configuration struct, register indexes and the parity/checksum helpers.
// No dependencies.
`timescale 1ns / 1ps

package lsfh_pkg;

    localparam logic [7:0] BREAK_BYTE = 8'h00;
    localparam logic [7:0] SYNC_BYTE  = 8'h55;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    localparam logic [2:0] CFG_RX_FRAME_ID      = 3'd0;
    localparam logic [2:0] CFG_RX_LENGTH        = 3'd1;
    localparam logic [2:0] CFG_TX_FRAME_ID      = 3'd2;
    localparam logic [2:0] CFG_TX_LENGTH        = 3'd3;
    localparam logic [2:0] CFG_TX_RESPONSE_DATA = 3'd4;

    typedef enum logic [2:0] {
        KIND_TX         = 3'd0,
        KIND_RX_FRAME   = 3'd1,
        KIND_PARITY_ERR = 3'd2,
        KIND_CSUM_ERR   = 3'd3,
        KIND_UNKNOWN_ID = 3'd4
    } kind_t;

    typedef struct packed {
        logic [5:0]  rx_frame_id;
        logic [3:0]  rx_length;
        logic [5:0]  tx_frame_id;
        logic [3:0]  tx_length;
        logic [63:0] tx_response_data;
    } cfg_t;

    typedef struct packed {
        kind_t       kind;
        logic [5:0]  frame_id;
        logic [7:0]  pid;
        logic [63:0] data;
        logic [3:0]  count;
    } cmd_t;

    function automatic logic [7:0] make_pid(input logic [5:0] id);
        logic p0;
        logic p1;
        p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
        p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
        return {p1, p0, id};
    endfunction

    function automatic logic [7:0] csum_add(input logic [7:0] sum, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, sum} + {1'b0, b};
        return s[8] ? (s[7:0] + 8'd1) : s[7:0];
    endfunction

endpackage

>>> rtl/lsfh_front.sv
// Front end of the LIN slave frame handler: header tracking, ID check,
// receive data collection and command generation. Depends on lsfh_pkg.
`timescale 1ns / 1ps

module lsfh_front #(
    parameter int MAX_DATA_BYTES = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  lsfh_pkg::cfg_t cfg,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [7:0]    s_rx_byte,
    input  logic          q_full,
    output logic          q_push,
    output lsfh_pkg::cmd_t q_cmd
);
    import lsfh_pkg::*;

    typedef enum logic [2:0] {
        PH_BREAK,
        PH_SYNC,
        PH_ID,
        PH_DATA,
        PH_CSUM,
        PH_ECHO
    } phase_t;

    localparam logic [3:0] MAX_LEN = 4'(MAX_DATA_BYTES);

    phase_t      phase_reg, phase_next;
    logic [7:0]  pid_reg, pid_next;
    logic [3:0]  byte_count_reg, byte_count_next;
    logic [3:0]  echo_count_reg, echo_count_next;
    logic [3:0]  frame_len_reg, frame_len_next;
    logic [7:0]  sum_reg, sum_next;
    logic [63:0] data_reg, data_next;

    logic       accept;
    logic [5:0] id;
    logic       pid_ok;
    logic [3:0] tx_len;

    function automatic logic [3:0] clamp_len(input logic [3:0] v);
        if (v == 4'd0) begin
            return 4'd1;
        end
        if (v > MAX_LEN) begin
            return MAX_LEN;
        end
        return v;
    endfunction

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign id      = s_rx_byte[5:0];
    assign pid_ok  = (s_rx_byte == make_pid(id));
    assign tx_len  = clamp_len(cfg.tx_length);

    always_comb begin
        phase_next      = phase_reg;
        pid_next        = pid_reg;
        byte_count_next = byte_count_reg;
        echo_count_next = echo_count_reg;
        frame_len_next  = frame_len_reg;
        sum_next        = sum_reg;
        data_next       = data_reg;
        q_push          = 1'b0;
        q_cmd.kind      = KIND_UNKNOWN_ID;
        q_cmd.frame_id  = id;
        q_cmd.pid       = s_rx_byte;
        q_cmd.data      = '0;
        q_cmd.count     = '0;
        if (accept) begin
            unique case (phase_reg)
                PH_BREAK: begin
                    if (s_rx_byte == BREAK_BYTE) phase_next = PH_SYNC;
                end
                PH_SYNC: begin
                    if (s_rx_byte == SYNC_BYTE) begin
                        phase_next = PH_ID;
                    end else if (s_rx_byte != BREAK_BYTE) begin
                        phase_next = PH_BREAK;
                    end
                end
                PH_ID: begin
                    pid_next = s_rx_byte;
                    if (!pid_ok) begin
                        q_push     = 1'b1;
                        q_cmd.kind = KIND_PARITY_ERR;
                        phase_next = PH_BREAK;
                    end else if (id == cfg.rx_frame_id) begin
                        frame_len_next  = clamp_len(cfg.rx_length);
                        byte_count_next = '0;
                        data_next       = '0;
                        sum_next        = s_rx_byte;
                        phase_next      = PH_DATA;
                    end else if (id == cfg.tx_frame_id) begin
                        q_push          = 1'b1;
                        q_cmd.kind      = KIND_TX;
                        q_cmd.data      = cfg.tx_response_data;
                        q_cmd.count     = tx_len;
                        echo_count_next = tx_len + 4'd1;
                        phase_next      = PH_ECHO;
                    end else begin
                        q_push     = 1'b1;
                        q_cmd.kind = KIND_UNKNOWN_ID;
                        phase_next = PH_BREAK;
                    end
                end
                PH_DATA: begin
                    data_next[{byte_count_reg[2:0], 3'b000} +: 8] = s_rx_byte;
                    sum_next        = csum_add(sum_reg, s_rx_byte);
                    byte_count_next = byte_count_reg + 4'd1;
                    if (byte_count_next >= frame_len_reg) phase_next = PH_CSUM;
                end
                PH_CSUM: begin
                    q_push         = 1'b1;
                    q_cmd.frame_id = pid_reg[5:0];
                    q_cmd.pid      = pid_reg;
                    if (s_rx_byte == ~sum_reg) begin
                        q_cmd.kind  = KIND_RX_FRAME;
                        q_cmd.data  = data_reg;
                        q_cmd.count = frame_len_reg;
                    end else begin
                        q_cmd.kind  = KIND_CSUM_ERR;
                    end
                    phase_next = PH_BREAK;
                end
                PH_ECHO: begin
                    echo_count_next = echo_count_reg - 4'd1;
                    if (echo_count_reg <= 4'd1) phase_next = PH_BREAK;
                end
                default: begin
                    phase_next = PH_BREAK;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_BREAK;
            pid_reg        <= '0;
            byte_count_reg <= '0;
            echo_count_reg <= '0;
            frame_len_reg  <= '0;
        end else begin
            phase_reg      <= phase_next;
            pid_reg        <= pid_next;
            byte_count_reg <= byte_count_next;
            echo_count_reg <= echo_count_next;
            frame_len_reg  <= frame_len_next;
        end
        sum_reg  <= sum_next;
        data_reg <= data_next;
    end

endmodule

>>> rtl/lsfh_queue.sv
// Short command queue between front and back of the LIN slave frame handler.
// Depends on lsfh_pkg.
`timescale 1ns / 1ps

module lsfh_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  lsfh_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           q_valid,
    output lsfh_pkg::cmd_t head_cmd
);
    import lsfh_pkg::*;

    localparam logic [QPTR_W:0] DEPTH_CNT = (QPTR_W + 1)'(QUEUE_DEPTH);

    cmd_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              do_push, do_pop;

    assign full     = (count_reg == DEPTH_CNT);
    assign q_valid  = (count_reg != '0);
    assign head_cmd = mem[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && q_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            unique case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
        if (do_push) mem[wr_ptr_reg] <= push_cmd;
    end

endmodule

>>> rtl/lsfh_back.sv
// Back end of the LIN slave frame handler: expands commands into result
// transactions and holds the output register. Depends on lsfh_pkg.
`timescale 1ns / 1ps

module lsfh_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_valid,
    input  lsfh_pkg::cmd_t head_cmd,
    output logic           q_pop,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [2:0]     m_kind,
    output logic [7:0]     m_tx_byte,
    output logic [63:0]    m_rx_data,
    output logic [3:0]     m_rx_count,
    output logic [5:0]     m_frame_id,
    output logic           m_last
);
    import lsfh_pkg::*;

    logic        m_valid_reg;
    kind_t       m_kind_reg;
    logic [7:0]  m_tx_byte_reg;
    logic [63:0] m_rx_data_reg;
    logic [3:0]  m_rx_count_reg;
    logic [5:0]  m_frame_id_reg;
    logic        m_last_reg;

    logic        busy_reg;
    logic [3:0]  remain_reg;
    logic [7:0]  sum_reg;
    logic [55:0] shift_reg;

    logic out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign q_pop    = out_free && !busy_reg && q_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            busy_reg    <= 1'b0;
        end else if (out_free) begin
            if (busy_reg) begin
                m_valid_reg <= 1'b1;
                m_kind_reg  <= KIND_TX;
                m_rx_data_reg  <= '0;
                m_rx_count_reg <= '0;
                if (remain_reg != 4'd0) begin
                    m_tx_byte_reg <= shift_reg[7:0];
                    m_last_reg    <= 1'b0;
                    sum_reg       <= csum_add(sum_reg, shift_reg[7:0]);
                    shift_reg     <= {8'h00, shift_reg[55:8]};
                    remain_reg    <= remain_reg - 4'd1;
                end else begin
                    m_tx_byte_reg <= ~sum_reg;
                    m_last_reg    <= 1'b1;
                    busy_reg      <= 1'b0;
                end
            end else if (q_valid) begin
                m_valid_reg    <= 1'b1;
                m_kind_reg     <= head_cmd.kind;
                m_frame_id_reg <= head_cmd.frame_id;
                m_rx_data_reg  <= head_cmd.data;
                m_rx_count_reg <= head_cmd.count;
                m_tx_byte_reg  <= 8'h00;
                m_last_reg     <= 1'b1;
                if (head_cmd.kind == KIND_TX) begin
                    m_rx_data_reg  <= '0;
                    m_rx_count_reg <= '0;
                    m_tx_byte_reg  <= head_cmd.data[7:0];
                    m_last_reg     <= 1'b0;
                    busy_reg       <= 1'b1;
                    sum_reg        <= csum_add(head_cmd.pid, head_cmd.data[7:0]);
                    shift_reg      <= head_cmd.data[63:8];
                    remain_reg     <= head_cmd.count - 4'd1;
                end
            end else begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_kind     = m_kind_reg;
    assign m_tx_byte  = m_tx_byte_reg;
    assign m_rx_data  = m_rx_data_reg;
    assign m_rx_count = m_rx_count_reg;
    assign m_frame_id = m_frame_id_reg;
    assign m_last     = m_last_reg;

    a_report_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_kind_reg != KIND_TX) |-> m_last_reg)
        else $error("non-transmit result without last");

    a_burst_holds_output: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> m_valid_reg)
        else $error("burst in progress with empty output register");

    a_no_pop_in_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !q_pop)
        else $error("queue popped during a response burst");

    a_count_only_on_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_kind_reg != KIND_RX_FRAME) |-> (m_rx_count_reg == 4'd0))
        else $error("received count on a result that is not a frame");

endmodule

>>> rtl/lin_slave_frame_handler_unit.sv
// LIN slave frame handler top level: configuration registers, front end,
// command queue and back end. Depends on lsfh_pkg, lsfh_front, lsfh_queue, lsfh_back.
//
// Usage:
//   s_valid/s_ready/s_rx_byte carry bytes from the bus UART, one transaction
//   per byte; a break reads as 0x00. m_valid/m_ready carry results: transmit
//   bytes (kind 0), received frames and error reports, m_last marking the
//   final result caused by one input byte.
//   cfg_wr_en/cfg_index/cfg_wdata write the five registers; write only while
//   the block is idle. Unknown indexes are ignored.
//   Throughput: one input byte per cycle while the command queue has room;
//   one result per cycle from the back end while m_ready is high. A response
//   burst of up to nine bytes is produced by the back end one byte per cycle
//   while m_ready is high and the front end keeps accepting echo bytes.
//   Result path: a result reaches the output register by way of the command
//   queue (queue write at the accepting edge of the byte that causes it, then
//   back-end register).
//   Stall: when m_ready is low the output register holds; the queue fills and
//   s_ready drops once it is full.
//   Reset: aresetn (synchronous, active low) returns to waiting for break,
//   empties the queue and loads the register defaults.
`timescale 1ns / 1ps

module lin_slave_frame_handler_unit #(
    parameter int MAX_DATA_BYTES = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic [7:0]  m_tx_byte,
    output logic [63:0] m_rx_data,
    output logic [3:0]  m_rx_count,
    output logic [5:0]  m_frame_id,
    output logic        m_last
);
    import lsfh_pkg::*;

    cfg_t cfg_reg;
    cmd_t push_cmd, head_cmd;
    logic q_push, q_full, q_pop, q_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rx_frame_id      <= 6'd0;
            cfg_reg.rx_length        <= 4'd8;
            cfg_reg.tx_frame_id      <= 6'd1;
            cfg_reg.tx_length        <= 4'd5;
            cfg_reg.tx_response_data <= 64'h0000_0001_9D60_0000;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_RX_FRAME_ID:      cfg_reg.rx_frame_id      <= cfg_wdata[5:0];
                CFG_RX_LENGTH:        cfg_reg.rx_length        <= cfg_wdata[3:0];
                CFG_TX_FRAME_ID:      cfg_reg.tx_frame_id      <= cfg_wdata[5:0];
                CFG_TX_LENGTH:        cfg_reg.tx_length        <= cfg_wdata[3:0];
                CFG_TX_RESPONSE_DATA: cfg_reg.tx_response_data <= cfg_wdata;
                default: ;
            endcase
        end
    end

    lsfh_front #(
        .MAX_DATA_BYTES(MAX_DATA_BYTES)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (push_cmd)
    );

    lsfh_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .q_valid  (q_valid),
        .head_cmd (head_cmd)
    );

    lsfh_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .head_cmd   (head_cmd),
        .q_pop      (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_kind     (m_kind),
        .m_tx_byte  (m_tx_byte),
        .m_rx_data  (m_rx_data),
        .m_rx_count (m_rx_count),
        .m_frame_id (m_frame_id),
        .m_last     (m_last)
    );

endmodule

>>> tb/tb.sv
// Self-checking testbench for lin_slave_frame_handler_unit: drives received bus bytes,
// predicts every transmit byte and frame report, and checks the result stream.
// Depends on lsfh_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb;
    import lsfh_pkg::*;

    localparam int MAX_DATA_BYTES = 8;
    localparam int QUIET_LIMIT = 2000;
    localparam logic [2:0] CFG_FIRST_UNUSED = CFG_TX_RESPONSE_DATA + 3'd1;

    typedef enum logic [2:0] {
        ST_BREAK,
        ST_SYNC,
        ST_PID,
        ST_DATA,
        ST_CSUM,
        ST_ECHO
    } lin_state_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  tx_byte;
        logic [63:0] rx_data;
        logic [3:0]  rx_count;
        logic [5:0]  frame_id;
        logic        last;
    } lin_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_kind;
    logic [7:0]  m_tx_byte;
    logic [63:0] m_rx_data;
    logic [3:0]  m_rx_count;
    logic [5:0]  m_frame_id;
    logic        m_last;

    logic [7:0]  bus_bytes_to_send[$];
    lin_result_t frame_results_due[$];
    lin_result_t due_result;

    cfg_t        live_cfg;
    lin_state_t  lin_st = ST_BREAK;
    logic [7:0]  held_pid = '0;
    logic [63:0] rx_buf = '0;
    int          data_cnt = 0;
    int          echo_left = 0;
    int          held_len = 0;

    bit          idling_on = 1'b0;
    int          send_gap = 0;
    int          hold_ready = 0;
    int          quiet_cycles = 0;
    int          error_count = 0;
    int          bytes_sent = 0;
    int          settings_used = 0;
    int          kinds_seen[5];

    lin_slave_frame_handler_unit #(
        .MAX_DATA_BYTES(MAX_DATA_BYTES)
    ) u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_byte  (s_rx_byte),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_kind     (m_kind),
        .m_tx_byte  (m_tx_byte),
        .m_rx_data  (m_rx_data),
        .m_rx_count (m_rx_count),
        .m_frame_id (m_frame_id),
        .m_last     (m_last)
    );

    always #4 aclk = ~aclk;

    function automatic logic [7:0] lin_pid(input logic [5:0] id);
        return {~^(id & 6'b111010), ^(id & 6'b010111), id};
    endfunction

    function automatic int lin_len(input logic [3:0] v);
        if (v == 4'd0) return 1;
        if (v > MAX_DATA_BYTES) return MAX_DATA_BYTES;
        return int'(v);
    endfunction

    // enhanced checksum: pid plus data, carries folded back in, inverted
    function automatic logic [7:0] enh_csum(input logic [7:0] pid, input logic [63:0] bytes,
                                            input int n);
        int acc;
        acc = int'(pid);
        for (int i = 0; i < n; i++) begin
            acc += bytes[8*i +: 8];
            if (acc > 255) acc -= 255;
        end
        return ~acc[7:0];
    endfunction

    function automatic void add_due(input kind_t k, input logic [7:0] txb,
                                    input logic [63:0] data, input logic [3:0] cnt,
                                    input logic [5:0] id, input logic last);
        lin_result_t r;
        r.kind = k;
        r.tx_byte = txb;
        r.rx_data = data;
        r.rx_count = cnt;
        r.frame_id = id;
        r.last = last;
        frame_results_due.push_back(r);
    endfunction

    function automatic void lin_track_byte(input logic [7:0] b);
        int len;
        case (lin_st)
            ST_BREAK: begin
                if (b == BREAK_BYTE) lin_st = ST_SYNC;
            end
            ST_SYNC: begin
                if (b == SYNC_BYTE) lin_st = ST_PID;
                else if (b != BREAK_BYTE) lin_st = ST_BREAK;
            end
            ST_PID: begin
                held_pid = b;
                if (b != lin_pid(b[5:0])) begin
                    lin_st = ST_BREAK;
                    add_due(KIND_PARITY_ERR, '0, '0, '0, b[5:0], 1'b1);
                end else if (b[5:0] == live_cfg.rx_frame_id) begin
                    held_len = lin_len(live_cfg.rx_length);
                    data_cnt = 0;
                    rx_buf = '0;
                    lin_st = ST_DATA;
                end else if (b[5:0] == live_cfg.tx_frame_id) begin
                    len = lin_len(live_cfg.tx_length);
                    for (int i = 0; i < len; i++) begin
                        add_due(KIND_TX, live_cfg.tx_response_data[8*i +: 8], '0, '0, b[5:0],
                                1'b0);
                    end
                    add_due(KIND_TX, enh_csum(b, live_cfg.tx_response_data, len), '0, '0,
                            b[5:0], 1'b1);
                    echo_left = len + 1;
                    lin_st = ST_ECHO;
                end else begin
                    lin_st = ST_BREAK;
                    add_due(KIND_UNKNOWN_ID, '0, '0, '0, b[5:0], 1'b1);
                end
            end
            ST_DATA: begin
                rx_buf[8*data_cnt +: 8] = b;
                data_cnt++;
                if (data_cnt >= held_len) lin_st = ST_CSUM;
            end
            ST_CSUM: begin
                lin_st = ST_BREAK;
                if (b != enh_csum(held_pid, rx_buf, held_len)) begin
                    add_due(KIND_CSUM_ERR, '0, '0, '0, held_pid[5:0], 1'b1);
                end else begin
                    add_due(KIND_RX_FRAME, '0, rx_buf, 4'(held_len), held_pid[5:0], 1'b1);
                end
            end
            ST_ECHO: begin
                if (echo_left > 0) echo_left--;
                if (echo_left == 0) lin_st = ST_BREAK;
            end
            default: begin
                lin_st = ST_BREAK;
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endfunction

    function automatic void queue_header(input logic [5:0] id, input bit good);
        logic [1:0] flip;
        flip = 2'($urandom_range(1, 3));
        bus_bytes_to_send.push_back(BREAK_BYTE);
        bus_bytes_to_send.push_back(SYNC_BYTE);
        bus_bytes_to_send.push_back(good ? lin_pid(id) : lin_pid(id) ^ {flip, 6'd0});
    endfunction

    function automatic void queue_rx_frame(input bit bad_sum);
        logic [63:0] payload;
        logic [7:0] flip;
        int n;
        n = lin_len(live_cfg.rx_length);
        payload = {$urandom, $urandom};
        flip = bad_sum ? 8'($urandom_range(1, 255)) : 8'd0;
        queue_header(live_cfg.rx_frame_id, 1'b1);
        for (int i = 0; i < n; i++) bus_bytes_to_send.push_back(payload[8*i +: 8]);
        bus_bytes_to_send.push_back(enh_csum(lin_pid(live_cfg.rx_frame_id), payload, n) ^ flip);
    endfunction

    function automatic void queue_tx_frame();
        int n;
        if (live_cfg.tx_frame_id == live_cfg.rx_frame_id) begin
            queue_rx_frame(1'b0);
        end else begin
            n = lin_len(live_cfg.tx_length) + 1;
            queue_header(live_cfg.tx_frame_id, 1'b1);
            for (int i = 0; i < n; i++) bus_bytes_to_send.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    function automatic void queue_unknown();
        logic [5:0] id;
        do id = 6'($urandom_range(0, 63));
        while (id == live_cfg.rx_frame_id || id == live_cfg.tx_frame_id);
        queue_header(id, 1'b1);
    endfunction

    function automatic void queue_random_sequence();
        int pick;
        int n;
        pick = $urandom_range(0, 19);
        if (pick < 10) begin
            queue_rx_frame(pick < 2);
        end else if (pick < 15) begin
            queue_tx_frame();
        end else if (pick == 15) begin
            queue_header(6'($urandom_range(0, 63)), 1'b0);
        end else if (pick == 16) begin
            queue_unknown();
        end else if (pick == 17) begin
            bus_bytes_to_send.push_back(BREAK_BYTE);
            bus_bytes_to_send.push_back(8'($urandom_range(0, 255)));
        end else begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++) bus_bytes_to_send.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    task automatic wait_idle();
        do @(negedge aclk);
        while (bus_bytes_to_send.size() != 0 || s_valid || frame_results_due.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            CFG_RX_FRAME_ID:      live_cfg.rx_frame_id = value[5:0];
            CFG_RX_LENGTH:        live_cfg.rx_length = value[3:0];
            CFG_TX_FRAME_ID:      live_cfg.tx_frame_id = value[5:0];
            CFG_TX_LENGTH:        live_cfg.tx_length = value[3:0];
            CFG_TX_RESPONSE_DATA: live_cfg.tx_response_data = value;
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [5:0] rid, input logic [3:0] rlen,
                                  input logic [5:0] tid, input logic [3:0] tlen,
                                  input logic [63:0] resp);
        logic [63:0] junk;
        wait_idle();
        junk = {$urandom, $urandom};
        write_reg(CFG_RX_FRAME_ID, {junk[63:6], rid});
        write_reg(CFG_RX_LENGTH, {junk[63:4], rlen});
        junk = {$urandom, $urandom};
        write_reg(CFG_TX_FRAME_ID, {junk[63:6], tid});
        write_reg(CFG_TX_LENGTH, {junk[63:4], tlen});
        write_reg(CFG_TX_RESPONSE_DATA, resp);
        for (int i = int'(CFG_FIRST_UNUSED); i < 8; i++) write_reg(i[2:0], {$urandom, $urandom});
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
        settings_used++;
    endtask

    // input channel: hold each transaction until accepted, predict on acceptance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                lin_track_byte(s_rx_byte);
                bytes_sent++;
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (bus_bytes_to_send.size() == 0) begin
                    s_valid <= 1'b0;
                end else if (idling_on && $urandom_range(0, 4) == 0) begin
                    send_gap = $urandom_range(0, 6);
                    s_valid <= 1'b0;
                end else begin
                    s_valid <= 1'b1;
                    s_rx_byte <= bus_bytes_to_send.pop_front();
                end
            end
        end
    end

    // result channel: compare each transaction against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (frame_results_due.size() == 0) begin
                $error("unexpected result: kind %0d frame_id 0x%0h", m_kind, m_frame_id);
                error_count++;
            end else begin
                due_result = frame_results_due.pop_front();
                check_field("kind", 64'(due_result.kind), 64'(m_kind));
                check_field("tx_byte", 64'(due_result.tx_byte), 64'(m_tx_byte));
                check_field("rx_data", due_result.rx_data, m_rx_data);
                check_field("rx_count", 64'(due_result.rx_count), 64'(m_rx_count));
                check_field("frame_id", 64'(due_result.frame_id), 64'(m_frame_id));
                check_field("last", 64'(due_result.last), 64'(m_last));
                kinds_seen[due_result.kind]++;
            end
        end
        if (hold_ready > 0) begin
            hold_ready--;
            m_ready <= 1'b0;
        end else if (idling_on && $urandom_range(0, 4) == 0) begin
            hold_ready = $urandom_range(0, 6);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        logic [5:0] rid;
        logic [5:0] tid;
        logic [3:0] rlen;
        logic [3:0] tlen;
        live_cfg.rx_frame_id = 6'd0;
        live_cfg.rx_length = 4'd8;
        live_cfg.tx_frame_id = 6'd1;
        live_cfg.tx_length = 4'd5;
        live_cfg.tx_response_data = 64'h1_9D60_0000;
        foreach (kinds_seen[k]) kinds_seen[k] = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // shared id (receive wins), zero length, repeated break, broken sync, all error kinds
        apply_settings(6'h3F, 4'd0, 6'h3F, 4'd0, {$urandom, $urandom});
        idling_on = 1'b1;
        bus_bytes_to_send.push_back(8'hFF);
        bus_bytes_to_send.push_back(BREAK_BYTE);
        queue_header(6'h3F, 1'b1);
        bus_bytes_to_send.push_back(8'hFF);
        bus_bytes_to_send.push_back(enh_csum(lin_pid(6'h3F), 64'hFF, 1));
        bus_bytes_to_send.push_back(BREAK_BYTE);
        bus_bytes_to_send.push_back(8'h13);
        queue_header(6'($urandom_range(0, 63)), 1'b0);
        queue_unknown();
        queue_rx_frame(1'b1);

        // oversized lengths clamp; full response burst with all-ones data
        apply_settings(6'h00, 4'd15, 6'h3F, 4'd15, '1);
        queue_tx_frame();

        for (int phase_idx = 0; phase_idx < 4; phase_idx++) begin
            if (phase_idx == 0) begin
                apply_settings(6'h00, 4'd1, 6'h3F, 4'd8, '0);
            end else if (phase_idx == 1) begin
                apply_settings(6'h3F, 4'd8, 6'h00, 4'd1, '1);
            end else begin
                rid = 6'($urandom_range(0, 63));
                tid = ($urandom_range(0, 5) == 0) ? rid : 6'($urandom_range(0, 63));
                rlen = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                                   : 4'($urandom_range(1, 8));
                tlen = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                                   : 4'($urandom_range(1, 8));
                apply_settings(rid, rlen, tid, tlen, {$urandom, $urandom});
            end
            idling_on = (phase_idx != 3) && ($urandom_range(0, 3) != 0);
            while (bus_bytes_to_send.size() < 14) queue_random_sequence();
        end

        wait_idle();
        repeat (6) @(negedge aclk);
        if (frame_results_due.size() != 0) begin
            $error("%0d predicted results never arrived", frame_results_due.size());
            error_count++;
        end
        $display("Drove %0d bus bytes under %0d register settings.", bytes_sent, settings_used);
        $display("Checked %0d transmit bytes, %0d frames, %0d parity, %0d checksum, %0d unknown id.",
                 kinds_seen[KIND_TX], kinds_seen[KIND_RX_FRAME], kinds_seen[KIND_PARITY_ERR],
                 kinds_seen[KIND_CSUM_ERR], kinds_seen[KIND_UNKNOWN_ID]);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
